// File: src/rsfm_pkg.sv
package rsfm_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int AW           = 32;
  localparam int SLOT_W       = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  localparam logic [1:0] REG_RECORD_START = 2'd0;
  localparam logic [1:0] REG_RECORD_STOP  = 2'd1;
  localparam logic [1:0] REG_FRAME_SIZE   = 2'd2;

  localparam logic [3:0] CMD_NONE      = 4'd0;
  localparam logic [3:0] CMD_LATCH     = 4'd1;
  localparam logic [3:0] CMD_FLUSH     = 4'd2;
  localparam logic [3:0] CMD_DIV_START = 4'd3;
  localparam logic [3:0] CMD_DIV_STORE = 4'd4;
  localparam logic [3:0] CMD_CALC      = 4'd5;
  localparam logic [3:0] CMD_READ      = 4'd6;
  localparam logic [3:0] CMD_DROP      = 4'd7;
  localparam logic [3:0] CMD_APPEND    = 4'd8;
  localparam logic [3:0] CMD_SKIP      = 4'd9;
  localparam logic [3:0] CMD_MUL       = 4'd10;
  localparam logic [3:0] CMD_FOLD      = 4'd11;
  localparam logic [3:0] CMD_RESULT    = 4'd12;

  localparam logic [1:0] DSEL_Q0 = 2'd0;
  localparam logic [1:0] DSEL_Q1 = 2'd1;
  localparam logic [1:0] DSEL_Q2 = 2'd2;
  localparam logic [1:0] DSEL_LK = 2'd3;

  typedef struct packed {
    logic [3:0] code;
    logic [1:0] div_sel;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic cnt_zero;
    logic cnt_full;
    logic touch;
    logic idx_end;
    logic hit;
    logic out_busy;
  } status_t;

  typedef struct packed {
    logic [AW-1:0] start_addr;
    logic [AW-1:0] end_addr;
    logic [AW-1:0] offset;
    logic [AW-1:0] frame_count;
    logic [AW-1:0] frame_bytes;
  } entry_t;

  function automatic logic span_has(input logic [AW-1:0] s, input logic [AW-1:0] e,
                                    input logic [AW-1:0] a);
    if (s <= e) begin
      return (a >= s) && (a <= e);
    end
    return (a >= s) || (a <= e);
  endfunction

  function automatic logic spans_touch(input logic [AW-1:0] s1, input logic [AW-1:0] e1,
                                       input logic [AW-1:0] s2, input logic [AW-1:0] e2);
    return span_has(s1, e1, s2) || span_has(s1, e1, e2) ||
           span_has(s2, e2, s1) || span_has(s2, e2, e1);
  endfunction

endpackage

// File: src/rsfm_div.sv
module rsfm_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [rsfm_pkg::AW-1:0] num,
  input  logic [rsfm_pkg::AW-1:0] den,
  output logic                   done,
  output logic [rsfm_pkg::AW-1:0] quo,
  output logic [rsfm_pkg::AW-1:0] rem
);

  localparam int STEP_W = $clog2(rsfm_pkg::AW + 1);

  logic [STEP_W-1:0]       step_r;
  logic [rsfm_pkg::AW-1:0] quo_r;
  logic [rsfm_pkg::AW-1:0] rem_r;
  logic [rsfm_pkg::AW-1:0] den_r;
  logic [rsfm_pkg::AW:0]   trial;
  logic [rsfm_pkg::AW:0]   diff;
  logic                    ge;

  assign trial = {rem_r, quo_r[rsfm_pkg::AW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (start) begin
      step_r <= STEP_W'(rsfm_pkg::AW);
    end else if (step_r != '0) begin
      step_r <= step_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (step_r != '0) begin
      quo_r <= {quo_r[rsfm_pkg::AW-2:0], ge};
      rem_r <= ge ? diff[rsfm_pkg::AW-1:0] : trial[rsfm_pkg::AW-1:0];
    end
  end

  assign done = (step_r == '0) && !start;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// File: src/rsfm_datapath.sv
module rsfm_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rsfm_pkg::cmd_t              cmd,
  output rsfm_pkg::status_t           status,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [31:0]                 cfg_data,
  input  logic [31:0]                 in_seg_start,
  input  logic [31:0]                 in_seg_end,
  input  logic [31:0]                 in_last_written,
  input  logic [31:0]                 in_position,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_found,
  output logic [31:0]                 out_address,
  output logic [3:0]                  out_seg_index,
  output logic [31:0]                 out_seg_frames,
  output logic [31:0]                 out_seg_offset,
  output logic [31:0]                 out_total_frames,
  output logic [4:0]                  out_total_segments
);

  localparam int AW = rsfm_pkg::AW;

  rsfm_pkg::entry_t mem [rsfm_pkg::MAX_SEGMENTS];
  rsfm_pkg::entry_t rd_r;
  rsfm_pkg::entry_t wr_entry;

  logic [AW-1:0] start_r, stop_r, fsize_r;
  logic [AW-1:0] s_r, e_r, l_r, pos_r;
  logic [AW-1:0] q0_r, q1_r, q2_r;
  logic [AW-1:0] n_r, o_r;
  logic [AW-1:0] total_r, count_r, prod_r;
  logic [rsfm_pkg::SLOT_W-1:0] oldest_r;
  logic [rsfm_pkg::CNT_W-1:0]  cnt_r, idx_r;

  logic          res_found_r;
  logic [AW-1:0] res_addr_r, res_frames_r, res_offs_r;
  logic [3:0]    res_idx_r;

  logic          out_valid_r;
  logic          out_found_r;
  logic [AW-1:0] out_addr_r, out_frames_r, out_offs_r, out_total_r;
  logic [3:0]    out_idx_r;
  logic [4:0]    out_segs_r;

  logic [AW-1:0] div_num, div_den, div_quo, div_rem;
  logic          div_done;
  logic [AW-1:0] rel, n_calc, ra;
  logic [AW-1:0] n_nxt;
  logic [rsfm_pkg::SLOT_W-1:0] rd_slot, wr_slot;
  logic          wrapped;

  assign wrapped = e_r < s_r;

  always_comb begin
    div_den = fsize_r;
    unique case (cmd.div_sel)
      rsfm_pkg::DSEL_Q0: div_num = wrapped ? stop_r - s_r : e_r - s_r;
      rsfm_pkg::DSEL_Q1: div_num = e_r - start_r;
      rsfm_pkg::DSEL_Q2: div_num = (wrapped && (l_r < e_r)) ? e_r - l_r : l_r - s_r;
      rsfm_pkg::DSEL_LK: begin
        div_num = rel + rd_r.offset;
        div_den = rd_r.frame_count;
      end
      default: div_num = '0;
    endcase
  end

  rsfm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.code == rsfm_pkg::CMD_DIV_START),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  assign rel     = pos_r - count_r;
  assign n_calc  = wrapped ? AW'(1) + q0_r + q1_r : AW'(1) + q0_r;
  assign ra      = rd_r.start_addr + prod_r;
  assign rd_slot = oldest_r + idx_r[rsfm_pkg::SLOT_W-1:0];
  assign wr_slot = oldest_r + cnt_r[rsfm_pkg::SLOT_W-1:0];
  assign n_nxt   = n_calc;

  assign wr_entry = '{start_addr: s_r, end_addr: e_r, offset: o_r,
                      frame_count: n_r, frame_bytes: fsize_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      stop_r  <= '0;
      fsize_r <= AW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        rsfm_pkg::REG_RECORD_START: start_r <= cfg_data;
        rsfm_pkg::REG_RECORD_STOP:  stop_r  <= cfg_data;
        rsfm_pkg::REG_FRAME_SIZE:   fsize_r <= (cfg_data == '0) ? AW'(1) : cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.code == rsfm_pkg::CMD_APPEND) begin
      mem[wr_slot] <= wr_entry;
    end
    if (cmd.code == rsfm_pkg::CMD_READ) begin
      rd_r <= mem[rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      cnt_r    <= '0;
      total_r  <= '0;
    end else begin
      case (cmd.code)
        rsfm_pkg::CMD_FLUSH: begin
          oldest_r <= '0;
          cnt_r    <= '0;
          total_r  <= '0;
        end
        rsfm_pkg::CMD_DROP: begin
          oldest_r <= oldest_r + 1'b1;
          cnt_r    <= cnt_r - 1'b1;
          total_r  <= total_r - rd_r.frame_count;
        end
        rsfm_pkg::CMD_APPEND: begin
          cnt_r   <= cnt_r + 1'b1;
          total_r <= total_r + n_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.code)
      rsfm_pkg::CMD_LATCH: begin
        s_r          <= in_seg_start;
        e_r          <= in_seg_end;
        l_r          <= in_last_written;
        pos_r        <= in_position;
        idx_r        <= '0;
        count_r      <= '0;
        res_found_r  <= 1'b0;
        res_addr_r   <= '0;
        res_idx_r    <= '0;
        res_frames_r <= '0;
        res_offs_r   <= '0;
      end
      rsfm_pkg::CMD_DIV_STORE: begin
        case (cmd.div_sel)
          rsfm_pkg::DSEL_Q0: q0_r <= div_quo;
          rsfm_pkg::DSEL_Q1: q1_r <= div_quo;
          default:           q2_r <= div_quo;
        endcase
      end
      rsfm_pkg::CMD_CALC: begin
        n_r <= n_nxt;
        if (l_r < e_r) begin
          o_r <= wrapped ? n_nxt - q2_r : q2_r + AW'(1);
        end else if (wrapped && (l_r != e_r)) begin
          o_r <= q2_r + AW'(1);
        end else begin
          o_r <= '0;
        end
      end
      rsfm_pkg::CMD_APPEND: begin
        res_found_r  <= 1'b1;
        res_idx_r    <= cnt_r[3:0];
        res_frames_r <= n_r;
        res_offs_r   <= o_r;
      end
      rsfm_pkg::CMD_SKIP: begin
        count_r <= count_r + rd_r.frame_count;
        idx_r   <= idx_r + 1'b1;
      end
      rsfm_pkg::CMD_MUL: begin
        prod_r <= div_rem * rd_r.frame_bytes;
      end
      rsfm_pkg::CMD_FOLD: begin
        res_found_r  <= 1'b1;
        res_addr_r   <= (ra >= stop_r) ? ra - (stop_r - start_r) : ra;
        res_idx_r    <= idx_r[3:0];
        res_frames_r <= rd_r.frame_count;
        res_offs_r   <= rd_r.offset;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.code == rsfm_pkg::CMD_RESULT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.code == rsfm_pkg::CMD_RESULT) begin
      out_found_r  <= res_found_r;
      out_addr_r   <= res_addr_r;
      out_idx_r    <= res_idx_r;
      out_frames_r <= res_frames_r;
      out_offs_r   <= res_offs_r;
      out_total_r  <= total_r;
      out_segs_r   <= cnt_r;
    end
  end

  assign status.div_done = div_done;
  assign status.cnt_zero = cnt_r == '0;
  assign status.cnt_full = cnt_r == rsfm_pkg::CNT_W'(rsfm_pkg::MAX_SEGMENTS);
  assign status.touch    = rsfm_pkg::spans_touch(s_r, e_r, rd_r.start_addr, rd_r.end_addr);
  assign status.idx_end  = idx_r == cnt_r;
  assign status.hit      = rel < rd_r.frame_count;
  assign status.out_busy = out_valid_r && !out_ready;

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_address        = out_addr_r;
  assign out_seg_index      = out_idx_r;
  assign out_seg_frames     = out_frames_r;
  assign out_seg_offset     = out_offs_r;
  assign out_total_frames   = out_total_r;
  assign out_total_segments = out_segs_r;

endmodule

// File: src/rsfm_ctrl.sv
module rsfm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_opcode,
  input  rsfm_pkg::status_t status,
  output rsfm_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_FLUSH     = 4'd1;
  localparam logic [3:0] S_DIV_GO    = 4'd2;
  localparam logic [3:0] S_DIV_WAIT  = 4'd3;
  localparam logic [3:0] S_CALC      = 4'd4;
  localparam logic [3:0] S_DROP_RD   = 4'd5;
  localparam logic [3:0] S_DROP_TEST = 4'd6;
  localparam logic [3:0] S_APPEND    = 4'd7;
  localparam logic [3:0] S_LK_RD     = 4'd8;
  localparam logic [3:0] S_LK_TEST   = 4'd9;
  localparam logic [3:0] S_LK_DIV    = 4'd10;
  localparam logic [3:0] S_LK_WAIT   = 4'd11;
  localparam logic [3:0] S_LK_FOLD   = 4'd12;
  localparam logic [3:0] S_RESULT    = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic [1:0] dsel_r, dsel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dsel_r  <= rsfm_pkg::DSEL_Q0;
    end else begin
      state_r <= state_nxt;
      dsel_r  <= dsel_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    dsel_nxt    = dsel_r;
    cmd.code    = rsfm_pkg::CMD_NONE;
    cmd.div_sel = dsel_r;
    in_ready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.code = rsfm_pkg::CMD_LATCH;
          dsel_nxt = rsfm_pkg::DSEL_Q0;
          unique case (in_opcode)
            rsfm_pkg::OP_ADD:    state_nxt = S_DIV_GO;
            rsfm_pkg::OP_LOOKUP: state_nxt = S_LK_RD;
            rsfm_pkg::OP_FLUSH:  state_nxt = S_FLUSH;
            default:             state_nxt = S_RESULT;
          endcase
        end
      end
      S_FLUSH: begin
        cmd.code  = rsfm_pkg::CMD_FLUSH;
        state_nxt = S_RESULT;
      end
      S_DIV_GO: begin
        cmd.code  = rsfm_pkg::CMD_DIV_START;
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.code = rsfm_pkg::CMD_DIV_STORE;
          if (dsel_r == rsfm_pkg::DSEL_Q2) begin
            state_nxt = S_CALC;
          end else begin
            dsel_nxt  = dsel_r + 1'b1;
            state_nxt = S_DIV_GO;
          end
        end
      end
      S_CALC: begin
        cmd.code  = rsfm_pkg::CMD_CALC;
        state_nxt = S_DROP_RD;
      end
      S_DROP_RD: begin
        cmd.code  = rsfm_pkg::CMD_READ;
        state_nxt = S_DROP_TEST;
      end
      S_DROP_TEST: begin
        if (!status.cnt_zero && status.touch) begin
          cmd.code  = rsfm_pkg::CMD_DROP;
          state_nxt = S_DROP_RD;
        end else if (status.cnt_full) begin
          cmd.code  = rsfm_pkg::CMD_DROP;
          state_nxt = S_APPEND;
        end else begin
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd.code  = rsfm_pkg::CMD_APPEND;
        state_nxt = S_RESULT;
      end
      S_LK_RD: begin
        if (status.idx_end) begin
          state_nxt = S_RESULT;
        end else begin
          cmd.code  = rsfm_pkg::CMD_READ;
          state_nxt = S_LK_TEST;
        end
      end
      S_LK_TEST: begin
        if (status.hit) begin
          state_nxt = S_LK_DIV;
        end else begin
          cmd.code  = rsfm_pkg::CMD_SKIP;
          state_nxt = S_LK_RD;
        end
      end
      S_LK_DIV: begin
        cmd.code    = rsfm_pkg::CMD_DIV_START;
        cmd.div_sel = rsfm_pkg::DSEL_LK;
        state_nxt   = S_LK_WAIT;
      end
      S_LK_WAIT: begin
        cmd.div_sel = rsfm_pkg::DSEL_LK;
        if (status.div_done) begin
          cmd.code  = rsfm_pkg::CMD_MUL;
          state_nxt = S_LK_FOLD;
        end
      end
      S_LK_FOLD: begin
        cmd.code  = rsfm_pkg::CMD_FOLD;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (!status.out_busy) begin
          cmd.code  = rsfm_pkg::CMD_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: src/recording_segment_frame_mapper.sv
// Add: three divisions, then a table read and a drop for each dropped
// segment.
// Lookup: a table read and a test per segment walked, then on a hit one
// remainder division and one multiply.
// One item at a time: the next input is taken in the cycle after the result is
// loaded; loading stalls while an earlier result waits.
// Synchronous active-low reset empties the table and restores registers.
module recording_segment_frame_mapper (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_seg_start,
  input  logic [31:0] in_seg_end,
  input  logic [31:0] in_last_written,
  input  logic [31:0] in_position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [31:0] out_address,
  output logic [3:0]  out_seg_index,
  output logic [31:0] out_seg_frames,
  output logic [31:0] out_seg_offset,
  output logic [31:0] out_total_frames,
  output logic [4:0]  out_total_segments
);

  rsfm_pkg::cmd_t    cmd;
  rsfm_pkg::status_t status;

  rsfm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .status    (status),
    .cmd       (cmd)
  );

  rsfm_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_seg_start       (in_seg_start),
    .in_seg_end         (in_seg_end),
    .in_last_written    (in_last_written),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_found          (out_found),
    .out_address        (out_address),
    .out_seg_index      (out_seg_index),
    .out_seg_frames     (out_seg_frames),
    .out_seg_offset     (out_seg_offset),
    .out_total_frames   (out_total_frames),
    .out_total_segments (out_total_segments)
  );

endmodule

// File: verif/tb_top.sv
module tb_top;

  localparam logic [1:0] OP_NOP  = 2'd3;
  localparam logic [1:0] REG_BAD = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 600;

  typedef struct packed {
    logic        found;
    logic [31:0] address;
    logic [3:0]  seg_index;
    logic [31:0] seg_frames;
    logic [31:0] seg_offset;
    logic [31:0] total_frames;
    logic [4:0]  total_segments;
  } map_result_t;

  class frame_map_sb;
    bit [31:0] region_start, region_stop, fsize;
    bit [31:0] seg_s[16], seg_e[16], seg_off[16], seg_n[16], seg_fb[16];
    bit [3:0]  oldest;
    bit [4:0]  count;
    bit [31:0] total;
    map_result_t expq[$];
    int errors;

    function void clear();
      region_start = '0;
      region_stop  = '0;
      fsize        = 1;
      oldest       = '0;
      count        = '0;
      total        = '0;
      errors       = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        rsfm_pkg::REG_RECORD_START: region_start = data;
        rsfm_pkg::REG_RECORD_STOP:  region_stop  = data;
        rsfm_pkg::REG_FRAME_SIZE:   fsize        = (data == 0) ? 32'd1 : data;
        default: ;
      endcase
    endfunction

    function bit in_span(bit [31:0] s, bit [31:0] e, bit [31:0] a);
      if (s <= e) return (a >= s) && (a <= e);
      return (a >= s) || (a <= e);
    endfunction

    function bit overlaps(bit [31:0] s1, bit [31:0] e1, bit [31:0] s2, bit [31:0] e2);
      return in_span(s1, e1, s2) || in_span(s1, e1, e2) ||
             in_span(s2, e2, s1) || in_span(s2, e2, e1);
    endfunction

    function void drop_oldest();
      if (count == 0) return;
      total  = total - seg_n[oldest];
      oldest = oldest + 4'd1;
      count  = count - 5'd1;
    endfunction

    function void note_input(logic [1:0] op, logic [31:0] s, logic [31:0] e,
                             logic [31:0] l, logic [31:0] pos);
      map_result_t r;
      bit [31:0] n, o, d, t, cnt, rel, fr, ra;
      bit [3:0] slot;
      r = '0;
      if (op == rsfm_pkg::OP_ADD) begin
        n = 1;
        o = 0;
        if (e >= s) begin
          d = e - s;
          n = n + d / fsize;
          if (l < e) begin
            d = l - s;
            o = d / fsize + 1;
          end
        end else begin
          d = region_stop - s;
          n = n + d / fsize;
          d = e - region_start;
          n = n + d / fsize;
          if (l < e) begin
            d = e - l;
            o = n - d / fsize;
          end else if (l != e) begin
            d = l - s;
            o = d / fsize + 1;
          end
        end
        while (count > 0 && overlaps(s, e, seg_s[oldest], seg_e[oldest])) drop_oldest();
        if (count >= 16) drop_oldest();
        slot = oldest + count[3:0];
        seg_s[slot]   = s;
        seg_e[slot]   = e;
        seg_off[slot] = o;
        seg_n[slot]   = n;
        seg_fb[slot]  = fsize;
        count = count + 5'd1;
        total = total + n;
        r.found      = 1'b1;
        r.seg_index  = count[3:0] - 4'd1;
        r.seg_frames = n;
        r.seg_offset = o;
      end else if (op == rsfm_pkg::OP_LOOKUP) begin
        cnt = 0;
        for (int i = 0; i < count; i++) begin
          slot = oldest + i[3:0];
          rel  = pos - cnt;
          if (rel >= seg_n[slot]) begin
            cnt = cnt + seg_n[slot];
            continue;
          end
          t  = rel + seg_off[slot];
          fr = (seg_n[slot] != 0) ? t % seg_n[slot] : 32'd0;
          ra = seg_s[slot] + fr * seg_fb[slot];
          if (ra >= region_stop) ra = ra - (region_stop - region_start);
          r.found      = 1'b1;
          r.address    = ra;
          r.seg_index  = i[3:0];
          r.seg_frames = seg_n[slot];
          r.seg_offset = seg_off[slot];
          break;
        end
      end else if (op == rsfm_pkg::OP_FLUSH) begin
        oldest = '0;
        count  = '0;
        total  = '0;
      end
      r.total_frames   = total;
      r.total_segments = count;
      expq.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(map_result_t got);
      map_result_t x;
      if (expq.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      x = expq.pop_front();
      if (got.found != x.found)
        report($sformatf("found %0d exp %0d", got.found, x.found));
      if (got.address != x.address)
        report($sformatf("address %h exp %h", got.address, x.address));
      if (got.seg_index != x.seg_index)
        report($sformatf("seg_index %0d exp %0d", got.seg_index, x.seg_index));
      if (got.seg_frames != x.seg_frames)
        report($sformatf("seg_frames %h exp %h", got.seg_frames, x.seg_frames));
      if (got.seg_offset != x.seg_offset)
        report($sformatf("seg_offset %h exp %h", got.seg_offset, x.seg_offset));
      if (got.total_frames != x.total_frames)
        report($sformatf("total_frames %h exp %h", got.total_frames, x.total_frames));
      if (got.total_segments != x.total_segments)
        report($sformatf("total_segments %0d exp %0d", got.total_segments,
                         x.total_segments));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode = '0;
  logic [31:0] in_seg_start = '0;
  logic [31:0] in_seg_end = '0;
  logic [31:0] in_last_written = '0;
  logic [31:0] in_position = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_found;
  logic [31:0] out_address;
  logic [3:0]  out_seg_index;
  logic [31:0] out_seg_frames;
  logic [31:0] out_seg_offset;
  logic [31:0] out_total_frames;
  logic [4:0]  out_total_segments;

  frame_map_sb sb;
  int in_idle_pct  = 17;
  int out_idle_pct = 17;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;

  recording_segment_frame_mapper u_top (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_found, out_address, out_seg_index, out_seg_frames,
                       out_seg_offset, out_total_frames, out_total_segments});
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic send_item(logic [1:0] op, logic [31:0] s, logic [31:0] e,
                           logic [31:0] l, logic [31:0] pos);
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_seg_start    <= s;
    in_seg_end      <= e;
    in_last_written <= l;
    in_position     <= pos;
    do @(posedge clk); while (!in_ready);
    sb.note_input(op, s, e, l, pos);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expq.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_region(logic [31:0] rs, logic [31:0] re, logic [31:0] fs);
    drain();
    write_reg(rsfm_pkg::REG_RECORD_START, rs);
    write_reg(rsfm_pkg::REG_RECORD_STOP, re);
    write_reg(rsfm_pkg::REG_FRAME_SIZE, fs);
  endtask

  // well-formed segment inside the region, possibly wrapped
  task automatic send_segment();
    logic [31:0] span, s, e, l, len, lo;
    span = sb.region_stop - sb.region_start;
    if (span == 0 || sb.region_stop < sb.region_start) span = 32'hFFFF;
    s   = sb.region_start + $urandom_range(0, span - 1);
    len = $urandom_range(0, (span > 64) ? span / 6 : span - 1);
    e   = s + len;
    if (e >= sb.region_stop && sb.region_stop > sb.region_start) e = e - span;
    lo  = s + $urandom_range(0, len);
    if (lo >= sb.region_stop && sb.region_stop > sb.region_start) lo = lo - span;
    case ($urandom_range(3))
      0: l = e;
      1: l = $urandom;
      default: l = lo;
    endcase
    send_item(rsfm_pkg::OP_ADD, s, e, l, $urandom);
  endtask

  task automatic run_random(int n);
    int k;
    logic [31:0] pos;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      pos = (sb.total < 32'h100000) ? $urandom_range(0, sb.total + 3) : $urandom;
      if (k < 45) send_segment();
      else if (k < 85) send_item(rsfm_pkg::OP_LOOKUP, $urandom, $urandom, $urandom, pos);
      else if (k < 89) send_item(rsfm_pkg::OP_FLUSH, $urandom, $urandom, $urandom, $urandom);
      else if (k < 93) send_item(OP_NOP, $urandom, $urandom, $urandom, $urandom);
      else send_item(2'($urandom), $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(rsfm_pkg::OP_ADD, 32'h0, 32'h0, 32'h0, 32'h0);
    send_item(rsfm_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0);
    send_item(OP_NOP, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_item(rsfm_pkg::OP_FLUSH, 32'h0, 32'h0, 32'h0, 32'h0);

    set_region(32'h1000, 32'h2000, 32'd16);
    send_item(rsfm_pkg::OP_ADD, 32'h1100, 32'h11F0, 32'h1140, 32'h0);
    send_item(rsfm_pkg::OP_ADD, 32'h1200, 32'h12F0, 32'h12F0, 32'h0);
    send_item(rsfm_pkg::OP_ADD, 32'h1F00, 32'h1080, 32'h1040, 32'h0);
    send_item(rsfm_pkg::OP_ADD, 32'h1E00, 32'h10F0, 32'h1F40, 32'h0);
    send_item(rsfm_pkg::OP_ADD, 32'h1D00, 32'h1010, 32'h1010, 32'h0);
    for (int i = 0; i < 17; i++)
      send_item(rsfm_pkg::OP_ADD, 32'h1300 + i * 32'h40, 32'h1320 + i * 32'h40,
                32'h1310 + i * 32'h40, 32'h0);
    send_item(rsfm_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0);
    send_item(rsfm_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0, sb.total - 1);
    send_item(rsfm_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0, sb.total);
    send_item(rsfm_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0, 32'hFFFFFFFF);
    run_random(80);

    drain();
    write_reg(REG_BAD, $urandom);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_random(60);
    in_idle_pct  = 17;
    out_idle_pct = 17;

    set_region(32'h0, 32'hFFFFFFFF, 32'h0);
    send_item(rsfm_pkg::OP_ADD, 32'h0, 32'hFFFFFFFF, 32'h0, 32'h0);
    send_item(rsfm_pkg::OP_ADD, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h0);
    send_item(rsfm_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0);
    run_random(60);

    set_region(32'hFFFFF000, 32'hFFFFFFFF, 32'hFFFFFFFF);
    run_random(60);

    set_region(32'h100, 32'h180, 32'd1);
    hold_reqs = hold_reqs + 1;
    run_random(80);

    set_region(32'h1000, 32'h2000, 32'd16);
    run_random(60);

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.expq.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
